// File: rtl/wbps_pkg.sv
// Shared constants and types for the wildcard byte pattern scanner.
package wbps_pkg;

   localparam int MAX_PATTERN_BYTES = 8;
   localparam int BYTE_W            = 8;
   localparam int POS_W             = 32;
   localparam int LEN_W             = 4;
   localparam int SEL_W             = $clog2(MAX_PATTERN_BYTES);
   localparam int PAT_W             = MAX_PATTERN_BYTES * BYTE_W;
   localparam int CSR_IDX_W         = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES  = 2'd0,
      CSR_CARE_MASK      = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2,
      CSR_SECTION_START  = 2'd3
   } csr_index_type;

   typedef logic [BYTE_W-1:0] window_type [MAX_PATTERN_BYTES];

   localparam logic [PAT_W-1:0]             PATTERN_RESET = '0;
   localparam logic [MAX_PATTERN_BYTES-1:0] CARE_RESET    = '1;
   localparam logic [LEN_W-1:0]             LENGTH_RESET  = LEN_W'(MAX_PATTERN_BYTES);
   localparam logic [POS_W-1:0]             START_RESET   = '0;
   localparam logic [POS_W-1:0]             POS_MAX       = '1;

endpackage

// File: rtl/wbps_match.sv
// Window compare against the masked signature, aligned to the newest byte.
module wbps_match
   import wbps_pkg::*;
(
   input  window_type                     window,
   input  logic [PAT_W-1:0]               pattern_bytes,
   input  logic [MAX_PATTERN_BYTES-1:0]   care_mask,
   input  logic [LEN_W-1:0]               length,
   output logic                           hit
);

   logic [MAX_PATTERN_BYTES-1:0] used;
   logic [MAX_PATTERN_BYTES-1:0] bad;
   logic [SEL_W-1:0]             sel [MAX_PATTERN_BYTES];
   logic [LEN_W-1:0]             sel_wide [MAX_PATTERN_BYTES];

   // window[j] lines up with signature byte length-1-j
   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         used[j]     = (LEN_W'(j) < length);
         sel_wide[j] = length - LEN_W'(1) - LEN_W'(j);
         sel[j]      = sel_wide[j][SEL_W-1:0];
         bad[j]      = used[j] && care_mask[sel[j]] &&
                       (window[j] != pattern_bytes[BYTE_W*sel[j] +: BYTE_W]);
      end
      // used doubles as the mask of signature bytes in use
      hit = (|(care_mask & used)) && !(|bad);
   end

endmodule

// File: rtl/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner.
//
// Scans a section one byte per request on the req_ channel for a signature
// of up to eight bytes with per-byte wildcards. Each match that starts at or
// beyond the end of the previous match yields one rsp_ item carrying
// section_start plus the match start; other requests yield nothing.
// req_tlast marks a section's last byte; position, window and match fence
// restart after it.
// Registers are written on the csr_ channel (index 0 pattern bytes, 1 care
// mask, 2 pattern length, 3 section start), which is always ready; write
// them only while no request is in flight.
// An accepted request is loaded into the input register and its result into the
// result register once that is free. Throughput: one request per cycle while
// the output is not stalled, limited by the combinational window compare and
// fence update.
// When rsp_tready is low the result register holds and req_tready drops
// once the input register is also occupied; nothing is lost.
// Reset (synchronous, active high) empties both registers, clears window,
// position and fence, and loads the register defaults.
module wildcard_byte_pattern_scanner
   import wbps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // end_of_section
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [31:0] match_offset
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PAT_W-1:0]     csr_data
);

   logic [PAT_W-1:0]             pattern_ff;
   logic [MAX_PATTERN_BYTES-1:0] care_ff;
   logic [LEN_W-1:0]             length_ff;
   logic [POS_W-1:0]             section_start_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff;
   logic              s1_last_ff;

   window_type        window_ff, window_in, window_shift;
   logic [POS_W-1:0]  position_ff, position_in;
   logic [POS_W-1:0]  fence_ff, fence_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_offset_ff, rsp_offset_in;

   logic              out_free, advance, accept;
   logic [LEN_W-1:0]  len_eff;
   logic              long_enough, window_hit, hit;
   logic [POS_W-1:0]  start;
   logic [POS_W:0]    fence_sum;

   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_offset_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff       <= PATTERN_RESET;
         care_ff          <= CARE_RESET;
         length_ff        <= LENGTH_RESET;
         section_start_ff <= START_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:  pattern_ff       <= csr_data;
            CSR_CARE_MASK:      care_ff          <= csr_data[MAX_PATTERN_BYTES-1:0];
            CSR_PATTERN_LENGTH: length_ff        <= csr_data[LEN_W-1:0];
            CSR_SECTION_START:  section_start_ff <= csr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_eff = (length_ff > LEN_W'(MAX_PATTERN_BYTES)) ?
                LEN_W'(MAX_PATTERN_BYTES) : length_ff;

      window_shift[0] = s1_data_ff;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         window_shift[k] = window_ff[k-1];
      end

      long_enough = (len_eff != '0) &&
                    (({1'b0, position_ff} + (POS_W+1)'(1)) >= (POS_W+1)'(len_eff));
      start       = position_ff - (POS_W'(len_eff) - POS_W'(1));
      fence_sum   = {1'b0, start} + (POS_W+1)'(len_eff);
      hit         = long_enough && (start >= fence_ff) && window_hit;
   end

   wbps_match u_match (
      .window        (window_shift),
      .pattern_bytes (pattern_ff),
      .care_mask     (care_ff),
      .length        (len_eff),
      .hit           (window_hit)
   );

   // Section state advances once per request leaving the input register
   always_comb begin
      window_in   = window_ff;
      position_in = position_ff;
      fence_in    = fence_ff;
      if (advance) begin
         if (s1_last_ff) begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
               window_in[k] = '0;
            end
            position_in = '0;
            fence_in    = '0;
         end else begin
            window_in = window_shift;
            if (position_ff != POS_MAX) begin
               position_in = position_ff + POS_W'(1);
            end
            if (hit) begin
               fence_in = fence_sum[POS_W] ? POS_MAX : fence_sum[POS_W-1:0];
            end
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      if (advance) begin
         rsp_valid_in  = hit;
         rsp_offset_in = section_start_ff + start;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         position_ff  <= '0;
         fence_ff     <= '0;
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         position_ff  <= position_in;
         fence_ff     <= fence_in;
         window_ff    <= window_in;
      end
   end

   // Payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      rsp_offset_ff <= rsp_offset_in;
   end

endmodule
